/* hdl/fpp_pkg.sv */
// Shared types and constants for the fading particle pool.
`default_nettype none
package fpp_pkg;

    localparam logic [1:0] FUNC_TICK   = 2'd0;
    localparam logic [1:0] FUNC_CREATE = 2'd1;
    localparam logic [1:0] FUNC_READ   = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // One pool entry as stored in the entry memory.
    typedef struct packed {
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [31:0] color;
        logic [15:0] size;
        logic [30:0] life;
        logic [31:0] birth;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

/* hdl/fpp_divider.sv */
// Restoring divider: quotient of a 48-bit dividend by a 31-bit divisor, one bit a cycle.
`default_nettype none
module fpp_divider
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [47:0] dividend,
    input  wire logic [30:0] divisor,
    output logic             done,
    output logic [47:0]      quotient
);
    logic [47:0] quot_reg;
    logic [31:0] rem_reg;
    logic [30:0] dsr_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [31:0] trial;
    logic [31:0] shifted;

    assign shifted = {rem_reg[30:0], quot_reg[47]};
    assign trial   = shifted - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd47)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            dsr_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[31])
            begin
                rem_reg  <= trial;
                quot_reg <= {quot_reg[46:0], 1'b1};
            end
            else
            begin
                rem_reg  <= shifted;
                quot_reg <= {quot_reg[46:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;
endmodule
`default_nettype wire

/* hdl/fading_particle_pool.sv */
// Fading particle pool: entry memory, live-bit memory, sweep sequencer and fade divider.
// Tick: sweeps every entry, clearing expired live bits (one live-bit/entry read per cycle), then advances the clock.
// Create: takes the lowest free slot found by the sweep; a full pool sweeps every entry and returns not ok.
// Read: a live unexpired slot runs two bit-serial divisions (size, then alpha); otherwise answered without division.
// One word at a time; a new word is taken only when the output register is empty or being taken in that cycle.
// Reset: clearing pass over the live-bit memory; no word accepted until it ends.
`default_nettype none
module fading_particle_pool
#(
    parameter int POOL_ENTRIES = 16384
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // func[1:0], elapsed_ticks[17:2], pos_x[33:18], pos_y[49:34], color_rgba[81:50],
    // start_size[97:82], life_ticks[128:98], slot_index[142:129], zero fill to 144
    input  wire logic [143:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // ok[0], slot_used[14:1], corner_x[31:15], corner_y[48:32], drawn_size[64:49],
    // drawn_color[96:65], zero fill to 104
    output logic [103:0]      m_tdata
);
    import fpp_pkg::*;

    localparam int AW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b00000001,
        ST_IDLE  = 8'b00000010,
        ST_SWEEP = 8'b00000100,
        ST_RDWT  = 8'b00001000,
        ST_RDCHK = 8'b00010000,
        ST_DIV1  = 8'b00100000,
        ST_DIV2  = 8'b01000000,
        ST_OUT   = 8'b10000000
    } state_t;

    entry_t        mem_entry [POOL_ENTRIES];
    logic          mem_live  [POOL_ENTRIES];

    state_t        state_reg;
    logic [AW:0]   addr_reg;      // address issued to memories
    logic          rd_v_reg;      // read data valid for address rd_a_reg
    logic [AW-1:0] rd_a_reg;
    logic          rd_last_reg;
    entry_t        rd_entry;
    logic          rd_live;
    logic [1:0]    func_reg;
    logic [143:0]  in_reg;
    logic [31:0]   clock_reg;
    logic          out_v_reg;
    logic [103:0]  out_reg;
    logic          found_reg;

    // write port
    logic          we_e, we_l, wl_val;
    logic [AW-1:0] wa;
    entry_t        wd;

    // divider
    logic          div_start;
    logic [47:0]   div_dvd;
    logic [30:0]   div_dsr;
    logic          div_done;
    logic [47:0]   div_q;
    logic [15:0]   size_q_reg;
    logic [31:0]   age;
    logic [31:0]   remain;
    logic          zero_fade;

    fpp_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk)
    begin
        if (we_e)
            mem_entry[wa] <= wd;
        if (we_l)
            mem_live[wa] <= wl_val;
        rd_entry <= mem_entry[addr_reg[AW-1:0]];
        rd_live  <= mem_live[addr_reg[AW-1:0]];
    end

    assign s_tready = (state_reg == ST_IDLE) && !(out_v_reg && !m_tready);
    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_reg;

    assign age       = clock_reg - rd_entry.birth;
    assign zero_fade = (rd_entry.life == 31'd0) || (age > {1'b0, rd_entry.life});
    assign remain    = {1'b0, rd_entry.life} - age;
    assign div_dsr   = rd_entry.life;

    always_comb
    begin
        we_e      = 1'b0;
        we_l      = 1'b0;
        wl_val    = 1'b0;
        wa        = rd_a_reg;
        wd.pos_x  = in_reg[33:18];
        wd.pos_y  = in_reg[49:34];
        wd.color  = in_reg[81:50];
        wd.size   = in_reg[97:82];
        wd.life   = in_reg[128:98];
        wd.birth  = clock_reg;
        div_start = 1'b0;
        div_dvd   = 48'(rd_entry.size) * 48'(remain[30:0]);
        if (state_reg == ST_CLEAR)
        begin
            we_l = 1'b1;
            wa   = addr_reg[AW-1:0];
        end
        else if (state_reg == ST_SWEEP && rd_v_reg)
        begin
            if (func_reg == FUNC_TICK)
            begin
                if (rd_live && age > {1'b0, rd_entry.life})
                    we_l = 1'b1;
            end
            else if (!rd_live && !found_reg)
            begin
                we_l   = 1'b1;
                wl_val = 1'b1;
                we_e   = 1'b1;
            end
        end
        else if (state_reg == ST_RDCHK && rd_live && !zero_fade)
            div_start = 1'b1;
        else if (state_reg == ST_DIV1 && div_done)
        begin
            div_start = 1'b1;
            div_dvd   = 48'(rd_entry.color[7:0]) * 48'(remain[30:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            addr_reg    <= '0;
            rd_v_reg    <= 1'b0;
            rd_a_reg    <= '0;
            rd_last_reg <= 1'b0;
            func_reg    <= '0;
            in_reg      <= '0;
            out_v_reg   <= 1'b0;
            out_reg     <= '0;
            clock_reg   <= '0;
            found_reg   <= 1'b0;
            size_q_reg  <= '0;
        end
        else
        begin
            if (out_v_reg && m_tready)
                out_v_reg <= 1'b0;
            case (state_reg)
                ST_CLEAR:
                begin
                    addr_reg <= addr_reg + (AW+1)'(1);
                    if (addr_reg == (AW+1)'(POOL_ENTRIES - 1))
                    begin
                        addr_reg  <= '0;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (s_tvalid && s_tready)
                    begin
                        in_reg    <= s_tdata;
                        func_reg  <= s_tdata[1:0];
                        found_reg <= 1'b0;
                        rd_v_reg  <= 1'b0;
                        case (s_tdata[1:0])
                            FUNC_TICK, FUNC_CREATE:
                            begin
                                addr_reg  <= '0;
                                state_reg <= ST_SWEEP;
                            end
                            FUNC_READ:
                            begin
                                addr_reg  <= (AW+1)'(s_tdata[142:129]);
                                state_reg <= ST_RDWT;
                            end
                            default:
                            begin
                                out_reg   <= '0;
                                out_v_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                ST_SWEEP:
                begin
                    // issue one address per cycle; check its data in the next cycle
                    rd_v_reg    <= !addr_reg[AW] && addr_reg < (AW+1)'(POOL_ENTRIES);
                    rd_a_reg    <= addr_reg[AW-1:0];
                    rd_last_reg <= addr_reg == (AW+1)'(POOL_ENTRIES - 1);
                    if (addr_reg < (AW+1)'(POOL_ENTRIES))
                        addr_reg <= addr_reg + (AW+1)'(1);
                    if (rd_v_reg && func_reg == FUNC_CREATE && !rd_live && !found_reg)
                    begin
                        found_reg <= 1'b1;
                        out_reg   <= {89'd0, 14'(rd_a_reg), 1'b1};
                        out_v_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                    else if (rd_v_reg && rd_last_reg)
                    begin
                        if (func_reg == FUNC_TICK)
                        begin
                            clock_reg <= clock_reg + 32'(in_reg[17:2]);
                            out_reg   <= {103'd0, 1'b1};
                        end
                        else
                            out_reg <= '0;
                        out_v_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_RDWT:
                    state_reg <= ST_RDCHK;
                ST_RDCHK:
                begin
                    if (in_reg[142:129] >= 14'(POOL_ENTRIES) && POOL_ENTRIES < 16384
                        || !rd_live)
                    begin
                        out_reg   <= {89'd0, in_reg[142:129], 1'b0};
                        out_v_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                    else if (zero_fade)
                    begin
                        out_reg   <= {rd_entry.color[31:8], 8'd0, 16'd0,
                                      {rd_entry.pos_y[15], rd_entry.pos_y},
                                      {rd_entry.pos_x[15], rd_entry.pos_x},
                                      in_reg[142:129], 1'b1};
                        out_v_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                    else
                        state_reg <= ST_DIV1;
                end
                ST_DIV1:
                begin
                    if (div_done)
                    begin
                        size_q_reg <= div_q[15:0];
                        state_reg  <= ST_DIV2;
                    end
                end
                ST_DIV2:
                begin
                    if (div_done)
                        state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    out_reg   <= {rd_entry.color[31:8], div_q[7:0], size_q_reg,
                                  {rd_entry.pos_y[15], rd_entry.pos_y}
                                      - {2'b00, size_q_reg[15:1]},
                                  {rd_entry.pos_x[15], rd_entry.pos_x}
                                      - {2'b00, size_q_reg[15:1]},
                                  in_reg[142:129], 1'b1};
                    out_v_reg <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
